// ----- sv/cmeg_pkg.sv -----
// cmeg_pkg: types and constants for the cylinder mesh element generator
// no dependencies; used by cylinder_mesh_element_generator

package cmeg_pkg;

    localparam int SEG_W        = 13;
    localparam int IDX_W        = 14;
    localparam int COORD_W      = 16;
    localparam int RADIUS_W     = 15;
    localparam int HEIGHT_W     = 16;
    localparam int TRIG_BITS    = 16;
    localparam int REM_W        = 12;
    localparam int MAX_SEGMENTS = 4096;

    // pipeline layout
    localparam int DIV_STAGES   = TRIG_BITS / 2;
    localparam int ST_ANGLE     = DIV_STAGES + 1;
    localparam int ST_SQUARE    = ST_ANGLE + 1;
    localparam int NUM_TERMS    = 4;
    localparam int ST_LAST_TERM = ST_SQUARE + 3 * NUM_TERMS - 1;
    localparam int ST_POLY      = ST_LAST_TERM + 1;
    localparam int ST_Q15       = ST_POLY + 1;
    localparam int ST_SCALE     = ST_Q15 + 1;
    localparam int ST_OUT       = ST_SCALE + 1;
    localparam int NUM_STAGES   = ST_OUT + 1;

    localparam logic [32:0] PI_Q31      = 33'd6746518852;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam int          RECIP_SHIFT = 34;

    // series divisors: row 0 sine, row 1 cosine
    localparam logic [6:0] TERM_DIV [2][NUM_TERMS] = '{
        '{7'd72, 7'd42, 7'd20, 7'd6},
        '{7'd90, 7'd56, 7'd30, 7'd12}
    };

    // floor(2^34 / divisor), corrected by one compare after the multiply
    localparam logic [31:0] TERM_RECIP [2][NUM_TERMS] = '{
        '{32'((64'd1 << RECIP_SHIFT) / 64'd72), 32'((64'd1 << RECIP_SHIFT) / 64'd42),
          32'((64'd1 << RECIP_SHIFT) / 64'd20), 32'((64'd1 << RECIP_SHIFT) / 64'd6)},
        '{32'((64'd1 << RECIP_SHIFT) / 64'd90), 32'((64'd1 << RECIP_SHIFT) / 64'd56),
          32'((64'd1 << RECIP_SHIFT) / 64'd30), 32'((64'd1 << RECIP_SHIFT) / 64'd12)}
    };

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_SEGMENTS = 2'd2;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_FACE   = 1'b1;

    // per-item fields that ride alongside the trig datapath
    typedef struct packed {
        logic               out_of_range;
        logic               is_face;
        logic               is_ring;
        logic [1:0]         quad;
        logic [COORD_W-1:0] y_coord;
        logic [IDX_W-1:0]   corner_a;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_c;
    } side_t;

    // round Q2.30 to Q0.15, saturating
    function automatic logic [14:0] to_q15(input logic [31:0] v);
        logic [32:0] r;
        r = ({1'b0, v} + 33'd16384) >> 15;
        return (r > 33'd32767) ? 15'h7FFF : r[14:0];
    endfunction

endpackage

// ----- sv/cylinder_mesh_element_generator.sv -----
// cylinder_mesh_element_generator: streaming cylinder vertex and face generator
// depends on cmeg_pkg

// One item enters per cycle and its result passes through 26 register stages before
// reaching the output; the flow never drops below one item per cycle while
// m_tready stays high. The depth is set by the ring phase divider (two quotient
// bits per stage, eight stages) and the sine and cosine series, evaluated in
// parallel at three stages per term. A stall on the output side freezes the whole
// pipeline. Registers are written through the cfg port (always ready) and must
// only change while no item is in flight.

module cylinder_mesh_element_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // element_index[13:0], zero pad
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // x_coord, y_coord, z_coord, corner_a, corner_b,
                                   // corner_c, zero pad
    output logic [1:0]  m_tuser,   // out_of_range[0], is_face[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NS   = cmeg_pkg::NUM_STAGES;
    localparam int DS   = cmeg_pkg::DIV_STAGES;
    localparam int NT   = cmeg_pkg::NUM_TERMS;
    localparam int SW   = cmeg_pkg::SEG_W;
    localparam int RW   = cmeg_pkg::REM_W;
    localparam int LT   = cmeg_pkg::ST_LAST_TERM;
    localparam int TRIG_Q_W = cmeg_pkg::TRIG_BITS;

    logic                          adv;
    logic [NS-1:0]                 vld_reg;
    cmeg_pkg::side_t               side_reg [NS];

    logic [cmeg_pkg::RADIUS_W-1:0] radius_reg;
    logic [cmeg_pkg::HEIGHT_W-1:0] height_reg;
    logic [SW-1:0]                 segments_reg;
    logic [SW-1:0]                 seg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 15'd256;
            height_reg   <= 16'd512;
            segments_reg <= 13'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cmeg_pkg::REG_RADIUS:   radius_reg   <= cfg_data[14:0];
                cmeg_pkg::REG_HEIGHT:   height_reg   <= cfg_data;
                cmeg_pkg::REG_SEGMENTS: segments_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (segments_reg == '0)
            seg = SW'(1);
        else if (segments_reg > SW'(cmeg_pkg::MAX_SEGMENTS))
            seg = SW'(cmeg_pkg::MAX_SEGMENTS);
        else
            seg = segments_reg;
    end

    // flow control: everything moves when the output slot is free or taken
    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end

    // stage 0: decode index, build y and corners, seed the divider
    cmeg_pkg::side_t side_next;
    logic [RW-1:0]   rem_next;

    always_comb
    begin
        logic [14:0] idx;
        logic [14:0] s15;
        logic [14:0] ci;
        logic [14:0] ring_i;
        logic [15:0] half;
        logic        top;
        logic        bot;
        logic        ctop;
        logic        oor;

        idx    = {1'b0, s_tdata[13:0]};
        s15    = {2'b0, seg};
        half   = {1'b0, height_reg[15:1]};
        side_next = '0;
        side_next.is_face = s_tuser[0];
        ring_i = '0;
        ci     = '0;
        top    = 1'b0;
        bot    = 1'b0;
        ctop   = 1'b0;

        if (s_tuser[0] == cmeg_pkg::CMD_VERTEX)
        begin
            oor  = idx >= (s15 << 1) + 15'd4;
            top  = idx <= s15;
            bot  = !top && (idx <= (s15 << 1) + 15'd1);
            ctop = idx == (s15 << 1) + 15'd2;
            ring_i = top ? idx : idx - s15 - 15'd1;
            side_next.out_of_range = oor;
            side_next.is_ring      = !oor && (top || bot);
            if (!oor)
                side_next.y_coord = (top || ctop) ? half : 16'd0 - half;
        end
        else
        begin
            oor = idx >= (s15 << 2);
            side_next.out_of_range = oor;
            if (!oor)
            begin
                if (idx < (s15 << 1))
                begin
                    ci = idx >> 1;
                    if (!idx[0])
                    begin
                        side_next.corner_a = 14'(ci);
                        side_next.corner_b = 14'(ci + s15 + 15'd1);
                        side_next.corner_c = 14'(ci + 15'd1);
                    end
                    else
                    begin
                        side_next.corner_a = 14'(ci + 15'd1);
                        side_next.corner_b = 14'(ci + s15 + 15'd1);
                        side_next.corner_c = 14'(ci + s15 + 15'd2);
                    end
                end
                else if (idx < 15'(3 * s15))
                begin
                    ci = idx - (s15 << 1);
                    side_next.corner_a = 14'((s15 << 1) + 15'd2);
                    side_next.corner_b = 14'(ci + 15'd1);
                    side_next.corner_c = 14'(ci);
                end
                else
                begin
                    ci = idx - 15'(3 * s15);
                    side_next.corner_a = 14'((s15 << 1) + 15'd3);
                    side_next.corner_b = 14'(ci + s15 + 15'd1);
                    side_next.corner_c = 14'(ci + s15 + 15'd2);
                end
            end
        end

        // the seam point at i == s has phase zero
        rem_next = (side_next.is_ring && ring_i != s15) ? ring_i[RW-1:0] : '0;
    end

    logic [RW-1:0]           rem_reg [DS+1];
    logic [TRIG_Q_W-1:0]     quo_reg [DS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            rem_reg[0]  <= rem_next;
            quo_reg[0]  <= '0;
        end
    end

    // stages 1..8: phase = (i << 16) / s, two bits per stage
    genvar d;
    generate
        for (d = 1; d <= DS; d++)
        begin : g_div
            logic [RW-1:0]       rem_d;
            logic [TRIG_Q_W-1:0] quo_d;

            always_comb
            begin
                logic [SW-1:0] t;
                rem_d = rem_reg[d-1];
                quo_d = quo_reg[d-1];
                for (int b = 0; b < 2; b++)
                begin
                    t = {rem_d, 1'b0};
                    if (t >= seg)
                    begin
                        rem_d = RW'(t - seg);
                        quo_d = {quo_d[TRIG_Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_d = t[RW-1:0];
                        quo_d = {quo_d[TRIG_Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[d]  <= rem_d;
                    quo_reg[d]  <= quo_d;
                    side_reg[d] <= side_reg[d-1];
                end
            end
        end
    endgenerate

    // angle within the quadrant in Q1.30, then its square
    logic [30:0] x_reg  [cmeg_pkg::ST_ANGLE:LT];
    logic [31:0] x2_reg [cmeg_pkg::ST_SQUARE:LT];
    logic [46:0] angle_prod;
    logic [61:0] square_prod;
    cmeg_pkg::side_t side_angle;

    assign angle_prod  = 47'(quo_reg[DS][13:0]) * 47'(cmeg_pkg::PI_Q31);
    assign square_prod = 62'(x_reg[cmeg_pkg::ST_ANGLE]) * 62'(x_reg[cmeg_pkg::ST_ANGLE]);

    // quadrant comes from the top two phase bits
    always_comb
    begin
        side_angle      = side_reg[DS];
        side_angle.quad = quo_reg[DS][15:14];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[cmeg_pkg::ST_ANGLE]     <= angle_prod[46:16];
            side_reg[cmeg_pkg::ST_ANGLE]  <= side_angle;
            x_reg[cmeg_pkg::ST_SQUARE]    <= x_reg[cmeg_pkg::ST_ANGLE];
            x2_reg[cmeg_pkg::ST_SQUARE]   <= square_prod[61:30];
            side_reg[cmeg_pkg::ST_SQUARE] <= side_reg[cmeg_pkg::ST_ANGLE];
        end
    end

    genvar st;
    generate
        for (st = cmeg_pkg::ST_SQUARE + 1; st <= LT; st++)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[st]    <= x_reg[st-1];
                    x2_reg[st]   <= x2_reg[st-1];
                    side_reg[st] <= side_reg[st-1];
                end
            end
        end
    endgenerate

    // series terms: t = 1 - (x2 * t_prev) / divisor, three stages per term
    logic [31:0] n_reg  [2][1:NT-1];
    logic [29:0] q0_reg [2][NT];
    logic [31:0] nr_reg [2][NT];
    logic [30:0] t_reg  [2][NT];

    genvar ch, k;
    generate
        for (ch = 0; ch < 2; ch++)
        begin : g_ch
            for (k = 0; k < NT; k++)
            begin : g_term
                localparam int PS = cmeg_pkg::ST_SQUARE + 3 * k;
                logic [31:0] n_in;
                logic [63:0] recip_prod;
                logic [31:0] back;
                logic [31:0] rest;
                logic [29:0] quot;

                if (k == 0)
                begin : g_first
                    assign n_in = x2_reg[PS];
                end
                else
                begin : g_next
                    logic [62:0] mul_prod;
                    assign mul_prod = 63'(x2_reg[PS-1]) * 63'(t_reg[ch][k-1]);
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                            n_reg[ch][k] <= mul_prod[61:30];
                    end
                    assign n_in = n_reg[ch][k];
                end

                assign recip_prod = 64'(n_in) * 64'(cmeg_pkg::TERM_RECIP[ch][k]);
                assign back = 32'(q0_reg[ch][k]) * 32'(cmeg_pkg::TERM_DIV[ch][k]);
                assign rest = nr_reg[ch][k] - back;
                assign quot = q0_reg[ch][k] +
                              30'(rest >= 32'(cmeg_pkg::TERM_DIV[ch][k]));

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        q0_reg[ch][k] <= recip_prod[63:34];
                        nr_reg[ch][k] <= n_in;
                        t_reg[ch][k]  <= cmeg_pkg::Q30_ONE - 31'(quot);
                    end
                end
            end
        end
    endgenerate

    // final products, Q0.15 rounding, radius scaling, sign and output
    logic [31:0] ps_reg;
    logic [31:0] pc_reg;
    logic [14:0] sq_reg;
    logic [14:0] cq_reg;
    logic [29:0] px_reg;
    logic [29:0] pz_reg;
    logic        negx_reg;
    logic        negz_reg;
    logic [15:0] xo_reg;
    logic [15:0] zo_reg;

    logic [61:0] sin_prod;
    logic [62:0] cos_prod;
    logic [30:0] cos_half;
    logic [30:0] cos_val;
    logic [14:0] mag_x;
    logic [14:0] mag_z;
    logic [1:0]  quad_s;
    logic [15:0] mx;
    logic [15:0] mz;
    logic        ring_out;

    assign sin_prod = 62'(x_reg[LT]) * 62'(t_reg[0][NT-1]);
    assign cos_prod = 63'(x2_reg[LT]) * 63'(t_reg[1][NT-1]);
    assign cos_half = pc_reg[31:1];
    assign cos_val  = (cos_half >= cmeg_pkg::Q30_ONE) ? 31'd0 : cmeg_pkg::Q30_ONE - cos_half;
    assign quad_s   = side_reg[cmeg_pkg::ST_Q15].quad;
    // odd quadrants swap the roles of sine and cosine
    assign mag_x    = quad_s[0] ? sq_reg : cq_reg;
    assign mag_z    = quad_s[0] ? cq_reg : sq_reg;
    assign mx       = 16'((31'(px_reg) + 31'd16384) >> 15);
    assign mz       = 16'((31'(pz_reg) + 31'd16384) >> 15);
    assign ring_out = side_reg[cmeg_pkg::ST_SCALE].is_ring;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg   <= sin_prod[61:30];
            pc_reg   <= cos_prod[61:30];
            sq_reg   <= cmeg_pkg::to_q15(ps_reg);
            cq_reg   <= cmeg_pkg::to_q15({1'b0, cos_val});
            px_reg   <= 30'(mag_x) * 30'(radius_reg);
            pz_reg   <= 30'(mag_z) * 30'(radius_reg);
            negx_reg <= (quad_s == 2'd1) || (quad_s == 2'd2);
            negz_reg <= quad_s[1];
            xo_reg   <= !ring_out ? 16'd0 : (negx_reg ? 16'd0 - mx : mx);
            zo_reg   <= !ring_out ? 16'd0 : (negz_reg ? 16'd0 - mz : mz);

            side_reg[cmeg_pkg::ST_POLY]  <= side_reg[LT];
            side_reg[cmeg_pkg::ST_Q15]   <= side_reg[cmeg_pkg::ST_POLY];
            side_reg[cmeg_pkg::ST_SCALE] <= side_reg[cmeg_pkg::ST_Q15];
            side_reg[cmeg_pkg::ST_OUT]   <= side_reg[cmeg_pkg::ST_SCALE];
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tuser  = {side_reg[NS-1].is_face, side_reg[NS-1].out_of_range};
    assign m_tdata  = {6'd0,
                       side_reg[NS-1].corner_c,
                       side_reg[NS-1].corner_b,
                       side_reg[NS-1].corner_a,
                       zo_reg,
                       side_reg[NS-1].y_coord,
                       xo_reg};

endmodule
